[rtl/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define PAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen outside reset
`define PAT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/pat_pkg.sv]
`timescale 1ns / 1ps

package pat_pkg;

  localparam int unsigned IDX_W   = 24;
  localparam int unsigned MSG_W   = 8;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned CNK_W   = 7;
  localparam int unsigned MAP_W   = 64;
  localparam int unsigned VERD_W  = 3;
  localparam int unsigned QUO_W   = 6;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFGA_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [VERD_W-1:0] V_NEW      = 3'd0;
  localparam logic [VERD_W-1:0] V_DUP      = 3'd1;
  localparam logic [VERD_W-1:0] V_NOTRECV  = 3'd2;
  localparam logic [VERD_W-1:0] V_ERROR    = 3'd3;
  localparam logic [VERD_W-1:0] V_NOIMM    = 3'd4;
  localparam logic [VERD_W-1:0] V_WRONGMSG = 3'd5;
  localparam logic [VERD_W-1:0] V_BADIDX   = 3'd6;

  localparam logic [CFGA_W-1:0] REG_TOTAL  = 2'd0;
  localparam logic [CFGA_W-1:0] REG_CSIZE  = 2'd1;
  localparam logic [CFGA_W-1:0] REG_NCHUNK = 2'd2;
  localparam logic [CFGA_W-1:0] REG_MSGID  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] csize;
    logic [CNK_W-1:0] nchunks;
    logic [MSG_W-1:0] msgid;
  } cfg_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [CNT_W-1:0]  idx;
  } item_t;

endpackage

[rtl/pat_ram.sv]
`timescale 1ns / 1ps

module pat_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pat_front.sv]
`timescale 1ns / 1ps

module pat_front #(
  parameter int unsigned MAX_PACKETS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       is_receive_i,
  input  logic                       status_ok_i,
  input  logic                       has_imm_i,
  input  logic [pat_pkg::MSG_W-1:0]  msg_id_i,
  input  logic [pat_pkg::IDX_W-1:0]  packet_index_i,
  input  pat_pkg::cfg_t              cfg_i,
  output logic                       full_o,
  output logic                       item_valid_o,
  output pat_pkg::item_t             item_o,
  input  logic                       item_pop_i
);

  pat_pkg::item_t        ent_q [2];
  pat_pkg::item_t        cls;
  logic                  wptr_q, rptr_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [pat_pkg::IDX_W:0] idx_ext;

  assign idx_ext = {1'b0, packet_index_i};

  // classify in priority order
  always_comb begin
    cls.idx = packet_index_i[pat_pkg::CNT_W-1:0];
    priority if (!is_receive_i) begin
      cls.verdict = pat_pkg::V_NOTRECV;
    end else if (!status_ok_i) begin
      cls.verdict = pat_pkg::V_ERROR;
    end else if (!has_imm_i) begin
      cls.verdict = pat_pkg::V_NOIMM;
    end else if (msg_id_i != cfg_i.msgid) begin
      cls.verdict = pat_pkg::V_WRONGMSG;
    end else if ((idx_ext >= (pat_pkg::IDX_W + 1)'(cfg_i.total)) ||
                 (idx_ext >= (pat_pkg::IDX_W + 1)'(MAX_PACKETS))) begin
      cls.verdict = pat_pkg::V_BADIDX;
    end else begin
      cls.verdict = pat_pkg::V_NEW;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i && !item_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!accept_i && item_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ent_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept_i) begin
        wptr_q <= ~wptr_q;
      end
      if (item_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  assign full_o       = cnt_q[1];
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = ent_q[rptr_q];

endmodule

[rtl/pat_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pat_back #(
  parameter int unsigned MAX_PACKETS = 65536,
  parameter int unsigned MAX_CHUNKS  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pat_pkg::cfg_t               cfg_i,
  input  logic                        item_valid_i,
  input  pat_pkg::item_t              item_i,
  output logic                        item_pop_o,
  output logic                        clearing_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [pat_pkg::VERD_W-1:0]  verdict_o,
  output logic                        repost_o,
  output logic [pat_pkg::CNT_W-1:0]   pkt_count_o,
  output logic [pat_pkg::MAP_W-1:0]   chunk_done_map_o,
  output logic                        all_received_o
);

  localparam int unsigned WORDS = (MAX_PACKETS + 15) / 16;
  localparam int unsigned BAW   = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int unsigned CHW   = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned SHW   = pat_pkg::CNT_W + pat_pkg::QUO_W;
  localparam int unsigned EXW   = BAW + pat_pkg::CNT_W;
  localparam logic [BAW-1:0] LAST_WORD = BAW'(WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [BAW-1:0]                clr_q, clr_d;
  logic [pat_pkg::VERD_W-1:0]    verd_q, verd_d;
  logic [pat_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [pat_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [pat_pkg::CNT_W-1:0]     tdiff_q, tdiff_d;
  logic [pat_pkg::CNT_W-1:0]     len_q, len_d;
  logic [pat_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic [2:0]                    step_q, step_d;
  logic [pat_pkg::CNT_W-1:0]     unique_q, unique_d;
  logic [pat_pkg::MAP_W-1:0]     map_q, map_d;
  logic [MAX_CHUNKS-1:0]         cvalid_q, cvalid_d;
  logic                          out_valid_q, out_valid_d;
  logic                          load_out;

  logic [pat_pkg::VERD_W-1:0]    out_verd_q;
  logic                          out_repost_q;
  logic [pat_pkg::CNT_W-1:0]     out_count_q;
  logic [pat_pkg::MAP_W-1:0]     out_map_q;
  logic                          out_all_q;

  logic                          bm_we, bm_re;
  logic [BAW-1:0]                bm_waddr, bm_raddr;
  logic [pat_pkg::WORD_W-1:0]    bm_wdata, bm_rdata;
  logic                          c_we, c_re;
  logic [CHW-1:0]                c_addr;
  logic [pat_pkg::CNT_W-1:0]     c_wdata, c_rdata;

  logic [EXW-1:0]                word_in, word_cur;
  logic [pat_pkg::CNT_W-1:0]     csz;
  logic [SHW-1:0]                csz_sh, rem_ext;
  logic [pat_pkg::CNT_W:0]       len_sum;
  logic [pat_pkg::CNT_W-1:0]     cnt_cur, cnt_inc;

  assign word_in  = EXW'(item_i.idx >> 4);
  assign word_cur = EXW'(idx_q >> 4);
  assign csz      = (cfg_i.csize == '0) ? pat_pkg::CNT_W'(1) : cfg_i.csize;
  assign csz_sh   = SHW'(csz) << step_q;
  assign rem_ext  = SHW'(rem_q);
  assign len_sum  = (pat_pkg::CNT_W + 1)'(tdiff_q) + (pat_pkg::CNT_W + 1)'(rem_q);
  assign cnt_cur  = cvalid_q[quo_q[CHW-1:0]] ? c_rdata : '0;
  assign cnt_inc  = (cnt_cur == pat_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign c_addr   = quo_q[CHW-1:0];
  assign c_wdata  = cnt_inc;
  assign load_out = (state_q == S_EMIT) && (!out_valid_q || pop_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    verd_d      = verd_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    tdiff_d     = tdiff_q;
    len_d       = len_q;
    quo_d       = quo_q;
    step_d      = step_q;
    unique_d    = unique_q;
    map_d       = map_q;
    cvalid_d    = cvalid_q;
    item_pop_o  = 1'b0;
    bm_we       = 1'b0;
    bm_waddr    = word_cur[BAW-1:0];
    bm_wdata    = bm_rdata | (pat_pkg::WORD_W'(1) << idx_q[3:0]);
    bm_re       = 1'b0;
    bm_raddr    = word_in[BAW-1:0];
    c_we        = 1'b0;
    c_re        = 1'b0;
    out_valid_d = out_valid_q && !pop_i;

    unique case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          verd_d     = item_i.verdict;
          idx_d      = item_i.idx;
          if (item_i.verdict == pat_pkg::V_NEW) begin
            bm_re   = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_READ: begin
        if (bm_rdata[idx_q[3:0]]) begin
          verd_d  = pat_pkg::V_DUP;
          state_d = S_EMIT;
        end else begin
          bm_we   = 1'b1;
          if (unique_q != pat_pkg::CNT_MAX) begin
            unique_d = unique_q + 1'b1;
          end
          rem_d   = idx_q;
          tdiff_d = cfg_i.total - idx_q;
          quo_d   = '0;
          step_d  = 3'(pat_pkg::QUO_W - 1);
          if (SHW'(idx_q) >= (SHW'(csz) << pat_pkg::QUO_W)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_ext >= csz_sh) begin
          rem_d         = rem_q - csz_sh[pat_pkg::CNT_W-1:0];
          quo_d[step_q] = 1'b1;
        end
        if (step_q == 3'd0) begin
          state_d = S_LEN;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      S_LEN: begin
        len_d = (len_sum > (pat_pkg::CNT_W + 1)'(csz)) ? csz :
                len_sum[pat_pkg::CNT_W-1:0];
        if (((pat_pkg::CNK_W)'(quo_q) < cfg_i.nchunks) &&
            ((pat_pkg::CNK_W)'(quo_q) < (pat_pkg::CNK_W)'(MAX_CHUNKS))) begin
          c_re    = 1'b1;
          state_d = S_CRD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CRD: begin
        c_we                     = 1'b1;
        cvalid_d[quo_q[CHW-1:0]] = 1'b1;
        if (cnt_inc >= len_q) begin
          map_d[quo_q] = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  pat_ram #(
    .WIDTH (pat_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  pat_ram #(
    .WIDTH (pat_pkg::CNT_W),
    .DEPTH (MAX_CHUNKS)
  ) u_chunk (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_addr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_addr),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i) begin
    verd_q  <= verd_d;
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    tdiff_q <= tdiff_d;
    len_q   <= len_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    if (load_out) begin
      out_verd_q   <= verd_q;
      out_repost_q <= (verd_q == pat_pkg::V_NEW) || (verd_q == pat_pkg::V_ERROR) ||
                      (verd_q == pat_pkg::V_NOIMM);
      out_count_q  <= unique_q;
      out_map_q    <= map_q;
      out_all_q    <= (unique_q >= cfg_i.total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      unique_q    <= '0;
      map_q       <= '0;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      unique_q    <= unique_d;
      map_q       <= map_d;
      cvalid_q    <= cvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign clearing_o       = (state_q == S_CLEAR);
  assign empty_o          = !out_valid_q;
  assign verdict_o        = out_verd_q;
  assign repost_o         = out_repost_q;
  assign pkt_count_o      = out_count_q;
  assign chunk_done_map_o = out_map_q;
  assign all_received_o   = out_all_q;

  `PAT_ASSERT(a_count_mono, clk_i, rst_ni, 1'b1 |=> (unique_q >= $past(unique_q)))
  `PAT_ASSERT(a_map_mono, clk_i, rst_ni, 1'b1 |=> ((map_q & $past(map_q)) == $past(map_q)))
  `PAT_ASSERT_NEVER(a_no_pop_clear, clk_i, rst_ni, (state_q == S_CLEAR) && item_pop_o)

endmodule

[rtl/packet_arrival_tracker.sv]
// Path from accept to result: rejected words skip the bitmap, duplicates take a bitmap read,
// new packets at most a bitmap read-modify-write, 6-step chunk divide and chunk update.
// The back end sequencer works on a single word at a time; the front queue keeps taking
// new words while it is busy, until full, and a result left unpopped stalls the sequencer.
// Reset: config returns to its defaults; the bitmap store's (MAX_PACKETS+15)/16 words
// (4096 by default) are swept to zero while full stays high.
`timescale 1ns / 1ps

module packet_arrival_tracker #(
  parameter int unsigned MAX_PACKETS = 65536,
  parameter int unsigned MAX_CHUNKS  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        is_receive_i,
  input  logic                        status_ok_i,
  input  logic                        has_imm_i,
  input  logic [pat_pkg::MSG_W-1:0]   msg_id_i,
  input  logic [pat_pkg::IDX_W-1:0]   packet_index_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pat_pkg::VERD_W-1:0]  verdict_o,
  output logic                        repost_o,
  output logic [pat_pkg::CNT_W-1:0]   pkt_count_o,
  output logic [pat_pkg::MAP_W-1:0]   chunk_done_map_o,
  output logic                        all_received_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pat_pkg::CFGA_W-1:0]  cfg_index_i,
  input  logic [pat_pkg::CNT_W-1:0]   cfg_data_i
);

  pat_pkg::cfg_t  cfg_q;
  pat_pkg::item_t item;
  logic           item_valid, item_pop, clearing, front_full, accept;

  assign cfg_ready_o = 1'b1;
  assign full        = front_full || clearing;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total   <= pat_pkg::CNT_W'(1);
      cfg_q.csize   <= pat_pkg::CNT_W'(1);
      cfg_q.nchunks <= pat_pkg::CNK_W'(1);
      cfg_q.msgid   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pat_pkg::REG_TOTAL:  cfg_q.total   <= cfg_data_i;
        pat_pkg::REG_CSIZE:  cfg_q.csize   <= cfg_data_i;
        pat_pkg::REG_NCHUNK: cfg_q.nchunks <= cfg_data_i[pat_pkg::CNK_W-1:0];
        pat_pkg::REG_MSGID:  cfg_q.msgid   <= cfg_data_i[pat_pkg::MSG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pat_front #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .is_receive_i   (is_receive_i),
    .status_ok_i    (status_ok_i),
    .has_imm_i      (has_imm_i),
    .msg_id_i       (msg_id_i),
    .packet_index_i (packet_index_i),
    .cfg_i          (cfg_q),
    .full_o         (front_full),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  pat_back #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_CHUNKS  (MAX_CHUNKS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_pop_o       (item_pop),
    .clearing_o       (clearing),
    .pop_i            (pop),
    .empty_o          (empty),
    .verdict_o        (verdict_o),
    .repost_o         (repost_o),
    .pkt_count_o      (pkt_count_o),
    .chunk_done_map_o (chunk_done_map_o),
    .all_received_o   (all_received_o)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pat_pkg::*;

  localparam int unsigned PKT_SPACE   = 65536;
  localparam int unsigned CHUNK_SLOTS = 64;
  localparam int unsigned SETTLE      = 12;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic              repost;
    logic [CNT_W-1:0]  count;
    logic [MAP_W-1:0]  chunks;
    logic              all_in;
  } completion_report_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                is_receive = 1'b0;
  logic                status_ok = 1'b0;
  logic                has_imm = 1'b0;
  logic [MSG_W-1:0]    msg_id = '0;
  logic [IDX_W-1:0]    packet_index = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [VERD_W-1:0]   verdict;
  logic                repost;
  logic [CNT_W-1:0]    pkt_count;
  logic [MAP_W-1:0]    chunk_done_map;
  logic                all_received;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFGA_W-1:0]   cfg_index = '0;
  logic [CNT_W-1:0]    cfg_data = '0;

  // Shadow configuration and tracker state
  bit [CNT_W-1:0]      cfg_total = 1;
  bit [CNT_W-1:0]      cfg_csize = 1;
  bit [CNK_W-1:0]      cfg_nchunks = 1;
  bit [MSG_W-1:0]      cfg_msgid = 0;
  bit                  packet_seen [PKT_SPACE];
  bit [CNT_W-1:0]      chunk_tally [CHUNK_SLOTS];
  bit [MAP_W-1:0]      done_chunks = '0;
  bit [CNT_W-1:0]      unique_total = '0;

  completion_report_t  awaited_reports [$];
  int                  error_count = 0;
  int                  tx_idle_pct = 0;
  int                  rx_stall_pct = 0;
  int                  rx_hold_left = 0;
  int unsigned         window_base = 1;

  packet_arrival_tracker DUT (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .is_receive_i     (is_receive),
    .status_ok_i      (status_ok),
    .has_imm_i        (has_imm),
    .msg_id_i         (msg_id),
    .packet_index_i   (packet_index),
    .empty            (empty),
    .pop              (pop),
    .verdict_o        (verdict),
    .repost_o         (repost),
    .pkt_count_o      (pkt_count),
    .chunk_done_map_o (chunk_done_map),
    .all_received_o   (all_received),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic completion_report_t classify_completion(
    input logic rcv, input logic ok, input logic imm,
    input logic [MSG_W-1:0] mid, input logic [IDX_W-1:0] pidx
  );
    completion_report_t r;
    int unsigned csz;
    int unsigned c;
    int unsigned first_pkt;
    int unsigned span;
    if (!rcv) begin
      r.verdict = V_NOTRECV;
    end else if (!ok) begin
      r.verdict = V_ERROR;
    end else if (!imm) begin
      r.verdict = V_NOIMM;
    end else if (mid != cfg_msgid) begin
      r.verdict = V_WRONGMSG;
    end else if (pidx >= cfg_total || pidx >= PKT_SPACE) begin
      r.verdict = V_BADIDX;
    end else if (packet_seen[pidx[15:0]]) begin
      r.verdict = V_DUP;
    end else begin
      r.verdict = V_NEW;
      packet_seen[pidx[15:0]] = 1'b1;
      if (unique_total != CNT_MAX) unique_total++;
      csz = (cfg_csize == 0) ? 1 : cfg_csize;
      c = pidx / csz;
      if (c < cfg_nchunks && c < CHUNK_SLOTS) begin
        if (chunk_tally[c] != CNT_MAX) chunk_tally[c]++;
        first_pkt = c * csz;
        span = (first_pkt < cfg_total) ? cfg_total - first_pkt : 0;
        if (span > csz) span = csz;
        if (chunk_tally[c] >= span) done_chunks[c] = 1'b1;
      end
    end
    r.repost = (r.verdict == V_NEW || r.verdict == V_ERROR || r.verdict == V_NOIMM);
    r.count  = unique_total;
    r.chunks = done_chunks;
    r.all_in = (unique_total >= cfg_total);
    return r;
  endfunction

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      pop = 1'b0;
      rx_hold_left--;
    end else begin
      pop = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    completion_report_t e;
    if (rst_ni && pop && !empty) begin
      if (awaited_reports.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        e = awaited_reports.pop_front();
        if (verdict !== e.verdict) begin
          $error("verdict: expected %0d, got %0d", e.verdict, verdict);
          error_count++;
        end
        if (repost !== e.repost) begin
          $error("repost: expected %0d, got %0d", e.repost, repost);
          error_count++;
        end
        if (pkt_count !== e.count) begin
          $error("pkt_count: expected %0d, got %0d", e.count, pkt_count);
          error_count++;
        end
        if (chunk_done_map !== e.chunks) begin
          $error("chunk_done_map: expected %h, got %h", e.chunks, chunk_done_map);
          error_count++;
        end
        if (all_received !== e.all_in) begin
          $error("all_received: expected %0d, got %0d", e.all_in, all_received);
          error_count++;
        end
      end
    end
  end

  task automatic send_completion(
    input logic rcv, input logic ok, input logic imm,
    input logic [MSG_W-1:0] mid, input logic [IDX_W-1:0] pidx
  );
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push         = 1'b1;
    is_receive   = rcv;
    status_ok    = ok;
    has_imm      = imm;
    msg_id       = mid;
    packet_index = pidx;
    do @(posedge clk); while (full);
    awaited_reports.push_back(classify_completion(rcv, ok, imm, mid, pidx));
  endtask

  task automatic send_noise();
    int kind;
    kind = $urandom_range(5);
    case (kind)
      0: send_completion(1'b0, 1'($urandom), 1'($urandom), MSG_W'($urandom),
                         IDX_W'($urandom));
      1: send_completion(1'b1, 1'b0, 1'($urandom), MSG_W'($urandom), IDX_W'($urandom));
      2: send_completion(1'b1, 1'b1, 1'b0, MSG_W'($urandom), IDX_W'($urandom));
      3: send_completion(1'b1, 1'b1, 1'b1, cfg_msgid ^ MSG_W'($urandom_range(1, 255)),
                         IDX_W'($urandom));
      4: begin
        if ($urandom_range(1) == 0)
          send_completion(1'b1, 1'b1, 1'b1, cfg_msgid,
                          IDX_W'($urandom_range(cfg_total, 24'hFFFFFF)));
        else
          send_completion(1'b1, 1'b1, 1'b1, cfg_msgid,
                          IDX_W'(cfg_total + $urandom_range(7)));
      end
      default: begin
        if (cfg_total != 0)
          send_completion(1'b1, 1'b1, 1'b1, cfg_msgid,
                          IDX_W'($urandom_range(cfg_total - 1)));
        else
          send_completion(1'b1, 1'b1, 1'b1, cfg_msgid, IDX_W'($urandom_range(15)));
      end
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    push = 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFGA_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    push      = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TOTAL:  cfg_total   = val;
      REG_CSIZE:  cfg_csize   = val;
      REG_NCHUNK: cfg_nchunks = val[CNK_W-1:0];
      default:    cfg_msgid   = val[MSG_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure_window(input int n);
    int k;
    int unsigned csz;
    int unsigned tot;
    tot = window_base + n + (($urandom_range(3) == 0) ? $urandom_range(1, 40) : 0);
    k = $urandom_range(1, 64);
    csz = (window_base + n + k - 1) / k;
    if ($urandom_range(7) == 0) csz = $urandom_range(0, 4);
    write_register(REG_TOTAL, CNT_W'(tot));
    write_register(REG_CSIZE, CNT_W'(csz));
    case ($urandom_range(4))
      0:       write_register(REG_NCHUNK, CNT_W'(64));
      1:       write_register(REG_NCHUNK, CNT_W'($urandom_range(127)));
      default: write_register(REG_NCHUNK, CNT_W'(k));
    endcase
    write_register(REG_MSGID, CNT_W'($urandom_range(255)));
  endtask

  task automatic test_directed_cases();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_completion(1'b0, 1'b1, 1'b1, 8'h00, 24'd0);
    send_completion(1'b1, 1'b0, 1'b1, 8'h00, 24'd0);
    send_completion(1'b1, 1'b1, 1'b0, 8'h00, 24'd0);
    send_completion(1'b1, 1'b1, 1'b1, 8'hFF, 24'd0);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'd1);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'hFFFFFF);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'd0);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'd0);
    drain_results();
    write_register(REG_TOTAL, 17'd0);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'd0);
    send_completion(1'b1, 1'b1, 1'b1, 8'h00, 24'd5);
    drain_results();
    write_register(REG_TOTAL, 17'd65536);
    write_register(REG_CSIZE, 17'd65536);
    write_register(REG_NCHUNK, 17'd64);
    write_register(REG_MSGID, 17'h5A);
    send_completion(1'b1, 1'b1, 1'b1, 8'h5A, 24'd65534);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd65534);
    send_completion(1'b1, 1'b1, 1'b1, 8'h5A, 24'd65536);
    drain_results();
    write_register(REG_TOTAL, 17'h1FFFF);
    write_register(REG_CSIZE, 17'd0);
    write_register(REG_NCHUNK, 17'd127);
    write_register(REG_MSGID, 17'hA5);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd65535);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd65536);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'h1FFFE);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd63);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd64);
    send_completion(1'b1, 1'b1, 1'b1, 8'hA5, 24'd63);
    send_completion(1'b0, 1'b0, 1'b0, 8'h00, 24'd0);
    send_completion(1'b1, 1'b0, 1'b0, 8'hFF, 24'hFFFFFF);
    drain_results();
  endtask

  task automatic test_window_sweeps(input int target, input int tx_pct, input int rx_pct);
    int sent;
    int n;
    int j;
    int t;
    int unsigned swap;
    int unsigned slots [$];
    bit partial;
    sent = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (sent < target) begin
      drain_results();
      n = $urandom_range(8, 48);
      configure_window(n);
      slots.delete();
      for (j = 0; j < n; j++) slots.push_back(window_base + j);
      for (j = n - 1; j > 0; j--) begin
        t = $urandom_range(j);
        swap = slots[j];
        slots[j] = slots[t];
        slots[t] = swap;
      end
      partial = ($urandom_range(9) == 0);
      foreach (slots[j]) begin
        if (!(partial && $urandom_range(3) == 0)) begin
          send_completion(1'b1, 1'b1, 1'b1, cfg_msgid, IDX_W'(slots[j]));
          sent++;
        end
        while ($urandom_range(99) < 25) begin
          send_noise();
          sent++;
        end
      end
      window_base += n;
    end
    drain_results();
  endtask

  task automatic test_output_holdoff();
    int j;
    int n;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    n = 24;
    configure_window(n);
    rx_hold_left = 1000;
    for (j = 0; j < 110; j++) begin
      if ($urandom_range(4) == 0 && j / 4 < n)
        send_completion(1'b1, 1'b1, 1'b1, cfg_msgid, IDX_W'(window_base + j / 4));
      else
        send_noise();
    end
    window_base += n;
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    test_directed_cases();
    test_window_sweeps(330, 0, 0);
    test_window_sweeps(330, 87, 0);
    test_window_sweeps(330, 0, 87);
    test_output_holdoff();
    test_window_sweeps(330, 37, 37);
    drain_results();
    repeat (24) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
